// File: rtl/core/dor_pkg.sv
// Shared types, constants and the arctangent table of the disc overlap core.
// Used by every cell module and by the top level; depends on nothing.
`timescale 1ns / 1ps

package dor_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 16;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [35:0] HALF_PI_Q30 = 36'd1686629713;
  localparam logic [16:0] RATIO_ONE   = 17'h10000;

  // One rotation vector of a CORDIC lane.
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
  } dor_vec_t;

  // Sideband that travels with an item down the chains of cells.
  typedef struct packed {
    logic               touch;
    logic               one;
    logic               calc;
    logic               sat;
    logic [30:0]        q0;
    logic [30:0]        q1;
    logic [61:0]        den;
    logic signed [35:0] p0;
    logic signed [35:0] p1;
    logic [31:0]        s;
  } dor_side_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:    a = 32'h3243F6A8;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFC;
      5'd3:    a = 32'h07F56EA6;
      5'd4:    a = 32'h03FEAB76;
      5'd5:    a = 32'h01FFD55B;
      5'd6:    a = 32'h00FFFAAA;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEA;
      5'd9:    a = 32'h001FFFFD;
      5'd10:   a = 32'h000FFFFF;
      5'd11:   a = 32'h0007FFFF;
      5'd12:   a = 32'h0003FFFF;
      5'd13:   a = 32'h0001FFFF;
      5'd14:   a = 32'h0000FFFF;
      5'd15:   a = 32'h00007FFF;
      5'd16:   a = 32'h00003FFF;
      5'd17:   a = 32'h00001FFF;
      5'd18:   a = 32'h00000FFF;
      5'd19:   a = 32'h000007FF;
      5'd20:   a = 32'h000003FF;
      5'd21:   a = 32'h000001FF;
      5'd22:   a = 32'h000000FF;
      5'd23:   a = 32'h0000007F;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/disc_overlap_ratio_core.sv
// Top level of the disc overlap ratio core: front end, chains of cells, output.
// Depends on dor_pkg, dor_sqrt_cell, dor_cordic_cell and dor_div_cell.
//
// Usage. An item is two discs (centers and signed radii, Q11.4). It is taken
// at a rising edge where start_i is high and busy_o is low; busy_o is always
// low, so one item can enter in every cycle. Each item gives one result on
// overlap_ratio_o (Q1.16, 65536 means 1.0) and discs_touch_o, shown for
// exactly one cycle with done_o high. Results leave in the order items came.
// The pipeline holds five front-end stages, 32 square-root cells, three
// normalizing stages, one CORDIC cell per CORDIC stage (at most AtanEntries),
// two area stages, 16 divider cells and the output register. Throughput is
// one item per cycle.
// Reset clears only the valid bits of the pipeline, so no result appears
// until items arrive; payload registers are not reset. The receiver cannot
// stall, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps

module disc_overlap_ratio_core import dor_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] first_center_x_i,
  input  logic [15:0] first_center_y_i,
  input  logic [15:0] first_radius_i,
  input  logic [15:0] second_center_x_i,
  input  logic [15:0] second_center_y_i,
  input  logic [15:0] second_radius_i,
  output logic        done_o,
  output logic [16:0] overlap_ratio_o,
  output logic        discs_touch_o
);

  localparam int unsigned CordicN = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES
                                                                  : AtanEntries;

  // The core never stalls, so it is never busy.
  assign busy_o = 1'b0;

  // Stage 1: center differences and radius magnitudes.
  logic               s1_v_q;
  logic signed [16:0] dx_q, dy_q;
  logic [15:0]        r0_q, r1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= $signed({second_center_x_i[15], second_center_x_i})
          - $signed({first_center_x_i[15], first_center_x_i});
    dy_q <= $signed({second_center_y_i[15], second_center_y_i})
          - $signed({first_center_y_i[15], first_center_y_i});
    // A radius code of -32768 has magnitude 32768, which still fits 16 bits.
    r0_q <= first_radius_i[15] ? 16'(-first_radius_i) : first_radius_i;
    r1_q <= second_radius_i[15] ? 16'(-second_radius_i) : second_radius_i;
  end

  // Stage 2: all the squares, each from its own multiplier.
  logic               s2_v_q;
  logic [32:0]        dx2_q, dy2_q, sum2_q, diff2_q;
  logic [30:0]        q0_q, q1_q;
  logic               r0_lt_q, rzero_q;
  logic [16:0]        rsum;
  logic signed [16:0] rdiff;
  logic signed [33:0] dx2_full, dy2_full, diff2_full;
  logic [33:0]        sum2_full;
  logic [31:0]        q0_full, q1_full;

  always_comb begin
    rsum       = {1'b0, r0_q} + {1'b0, r1_q};
    rdiff      = $signed({1'b0, r0_q}) - $signed({1'b0, r1_q});
    dx2_full   = dx_q * dx_q;
    dy2_full   = dy_q * dy_q;
    diff2_full = rdiff * rdiff;
    sum2_full  = rsum * rsum;
    q0_full    = r0_q * r0_q;
    q1_full    = r1_q * r1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx2_q   <= dx2_full[32:0];
    dy2_q   <= dy2_full[32:0];
    sum2_q  <= sum2_full[32:0];
    diff2_q <= diff2_full[32:0];
    q0_q    <= q0_full[30:0];
    q1_q    <= q1_full[30:0];
    r0_lt_q <= r0_q < r1_q;
    rzero_q <= (r0_q == 16'd0) || (r1_q == 16'd0);
  end

  // Stage 3: squared distance, the case flags and the Heron factors.
  logic        s3_v_q;
  logic [33:0] d2;
  logic        touch, nested, strict;
  logic [32:0] fa_q, fb_q;
  logic [30:0] rmin2_q;
  dor_side_t   side3_d, side3_q;

  always_comb begin
    d2      = {1'b0, dx2_q} + {1'b0, dy2_q};
    touch   = d2 <= {1'b0, sum2_q};
    nested  = d2 <= {1'b0, diff2_q};
    strict  = d2 < {1'b0, sum2_q};
    side3_d       = '0;
    side3_d.touch = touch;
    side3_d.one   = touch && nested && !rzero_q;
    side3_d.calc  = touch && !nested && strict && !rzero_q;
    side3_d.q0    = q0_q;
    side3_d.q1    = q1_q;
    side3_d.p0    = $signed({5'b0, q0_q}) + $signed({2'b0, d2}) - $signed({5'b0, q1_q});
    side3_d.p1    = $signed({5'b0, q1_q}) + $signed({2'b0, d2}) - $signed({5'b0, q0_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  // The factors only matter for items strictly between the tangencies,
  // where both fit 33 bits.
  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    fa_q    <= sum2_q - d2[32:0];
    fb_q    <= d2[32:0] - diff2_q;
    rmin2_q <= r0_lt_q ? q0_q : q1_q;
  end

  // Stage 4: Heron product in two partial products, and the divisor.
  logic        s4_v_q;
  logic [49:0] flo_q;
  logic [48:0] fhi_q;
  logic [62:0] den_full;
  dor_side_t   side4_d, side4_q;

  assign den_full = PI_Q30 * rmin2_q;

  always_comb begin
    side4_d     = side3_q;
    side4_d.den = den_full[61:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flo_q   <= fa_q * fb_q[16:0];
    fhi_q   <= fa_q * fb_q[32:17];
    side4_q <= side4_d;
  end

  // Stage 5: the partial products are summed into the radicand.
  logic        s5_v_q;
  logic [63:0] rad_q;
  dor_side_t   side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= {14'b0, flo_q} + {fhi_q[46:0], 17'b0};
    side5_q <= side4_q;
  end

  // Square root: one cell per root bit, from the top pair of radicand bits.
  logic        sq_v    [0:SqrtSteps];
  logic [63:0] sq_rem  [0:SqrtSteps];
  logic [63:0] sq_root [0:SqrtSteps];
  dor_side_t   sq_side [0:SqrtSteps];

  assign sq_v[0]    = s5_v_q;
  assign sq_rem[0]  = rad_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_q;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    dor_sqrt_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .side_i  (sq_side[g]),
      .valid_o (sq_v[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .side_o  (sq_side[g+1])
    );
  end

  // Normalize, step 1: the starting vector of each angle lane. A negative
  // projection starts rotated by a quarter turn.
  logic           n1_v_q;
  dor_vec_t [1:0] n1_vec_d, n1_vec_q;
  dor_side_t      n1_side_d, n1_side_q;
  logic signed [35:0] proj;

  always_comb begin
    n1_side_d   = sq_side[SqrtSteps];
    n1_side_d.s = sq_root[SqrtSteps][31:0];
    for (int k = 0; k < 2; k++) begin
      proj = (k == 0) ? n1_side_d.p0 : n1_side_d.p1;
      if (proj[35]) begin
        n1_vec_d[k].x = {4'b0, n1_side_d.s};
        n1_vec_d[k].y = -proj;
        n1_vec_d[k].z = HALF_PI_Q30;
      end else begin
        n1_vec_d[k].x = proj;
        n1_vec_d[k].y = {4'b0, n1_side_d.s};
        n1_vec_d[k].z = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_v_q <= 1'b0;
    end else begin
      n1_v_q <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    n1_vec_q  <= n1_vec_d;
    n1_side_q <= n1_side_d;
  end

  // Normalize, step 2: leading one of the larger part of each vector.
  logic           n2_v_q;
  dor_vec_t [1:0] n2_vec_q;
  dor_side_t      n2_side_q;
  logic [5:0]     lead_d [2];
  logic [5:0]     lead_q [2];
  logic [35:0]    big;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      big = (n1_vec_q[k].x > n1_vec_q[k].y) ? n1_vec_q[k].x : n1_vec_q[k].y;
      lead_d[k] = '0;
      for (int j = 0; j < 36; j++) begin
        if (big[j]) begin
          lead_d[k] = 6'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n2_v_q <= 1'b0;
    end else begin
      n2_v_q <= n1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_vec_q  <= n1_vec_q;
    n2_side_q <= n1_side_q;
    lead_q    <= lead_d;
  end

  // Normalize, step 3: shift both parts so the larger lies in [2^30, 2^31).
  logic           cr_v    [0:CordicN];
  dor_vec_t [1:0] cr_vec  [0:CordicN];
  dor_side_t      cr_side [0:CordicN];
  logic           n3_v_q;
  dor_vec_t [1:0] n3_vec_d, n3_vec_q;
  dor_side_t      n3_side_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      n3_vec_d[k].z = n2_vec_q[k].z;
      if (lead_q[k] >= 6'd30) begin
        n3_vec_d[k].x = n2_vec_q[k].x >> (lead_q[k] - 6'd30);
        n3_vec_d[k].y = n2_vec_q[k].y >> (lead_q[k] - 6'd30);
      end else begin
        n3_vec_d[k].x = n2_vec_q[k].x << (6'd30 - lead_q[k]);
        n3_vec_d[k].y = n2_vec_q[k].y << (6'd30 - lead_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n3_v_q <= 1'b0;
    end else begin
      n3_v_q <= n2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n3_vec_q  <= n3_vec_d;
    n3_side_q <= n2_side_q;
  end

  assign cr_v[0]    = n3_v_q;
  assign cr_vec[0]  = n3_vec_q;
  assign cr_side[0] = n3_side_q;

  for (genvar g = 0; g < CordicN; g++) begin : g_cordic
    dor_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cr_v[g]),
      .vec_i   (cr_vec[g]),
      .side_i  (cr_side[g]),
      .valid_o (cr_v[g+1]),
      .vec_o   (cr_vec[g+1]),
      .side_o  (cr_side[g+1])
    );
  end

  // Area, step 1: each sector term is a squared radius times its angle.
  logic               m1_v_q;
  logic signed [63:0] prod0_q, prod1_q;
  dor_side_t          m1_side_q;
  logic signed [64:0] prod0_full, prod1_full;

  always_comb begin
    prod0_full = $signed({1'b0, cr_side[CordicN].q0})
               * $signed(cr_vec[CordicN][0].z[32:0]);
    prod1_full = $signed({1'b0, cr_side[CordicN].q1})
               * $signed(cr_vec[CordicN][1].z[32:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else begin
      m1_v_q <= cr_v[CordicN];
    end
  end

  always_ff @(posedge clk_i) begin
    prod0_q   <= prod0_full[63:0];
    prod1_q   <= prod1_full[63:0];
    m1_side_q <= cr_side[CordicN];
  end

  // Area, step 2: subtract the kite, clamp at zero and check for saturation.
  logic               m2_v_q;
  logic [63:0]        area_q;
  dor_side_t          m2_side_d, m2_side_q;
  logic signed [63:0] area_raw;
  logic [63:0]        area_pos;

  always_comb begin
    area_raw      = prod0_q + prod1_q - $signed({3'b0, m1_side_q.s, 29'b0});
    area_pos      = area_raw[63] ? 64'd0 : area_raw;
    m2_side_d     = m1_side_q;
    m2_side_d.sat = area_pos >= {2'b0, m1_side_q.den};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else begin
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q    <= area_pos;
    m2_side_q <= m2_side_d;
  end

  // Division of the area by the smaller disc area, one quotient bit a cell.
  logic        dv_v    [0:DivSteps];
  logic [63:0] dv_rem  [0:DivSteps];
  logic [15:0] dv_quo  [0:DivSteps];
  dor_side_t   dv_side [0:DivSteps];

  assign dv_v[0]    = m2_v_q;
  assign dv_rem[0]  = area_q;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = m2_side_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    dor_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[g]),
      .rem_i   (dv_rem[g]),
      .quo_i   (dv_quo[g]),
      .side_i  (dv_side[g]),
      .valid_o (dv_v[g+1]),
      .rem_o   (dv_rem[g+1]),
      .quo_o   (dv_quo[g+1]),
      .side_o  (dv_side[g+1])
    );
  end

  // Output register: the special cases override the quotient.
  logic        done_q, touch_q;
  logic [16:0] ratio_d, ratio_q;
  dor_side_t   fin;

  always_comb begin
    fin = dv_side[DivSteps];
    if (fin.one) begin
      ratio_d = RATIO_ONE;
    end else if (!fin.calc) begin
      ratio_d = '0;
    end else if (fin.sat) begin
      ratio_d = RATIO_ONE;
    end else begin
      ratio_d = {1'b0, dv_quo[DivSteps]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= ratio_d;
    touch_q <= fin.touch;
  end

  assign done_o          = done_q;
  assign overlap_ratio_o = ratio_q;
  assign discs_touch_o   = touch_q;

endmodule

// File: rtl/core/dor_sqrt_cell.sv
// One digit cell of the pipelined square root: decides one root bit.
// Depends on dor_pkg for the sideband type.
`timescale 1ns / 1ps

module dor_sqrt_cell import dor_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] root_i,
  input  dor_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] rem_o,
  output logic [63:0] root_o,
  output dor_side_t   side_o
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  logic        valid_q;
  logic [63:0] rem_d, rem_q, root_d, root_q, trial;
  dor_side_t   side_q;

  always_comb begin
    trial = root_i + Bit;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/dor_cordic_cell.sv
// One vectoring CORDIC cell working on both angle lanes of an item.
// Depends on dor_pkg for the vector and sideband types and the atan table.
`timescale 1ns / 1ps

module dor_cordic_cell import dor_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dor_vec_t [1:0]     vec_i,
  input  dor_side_t          side_i,
  output logic               valid_o,
  output dor_vec_t [1:0]     vec_o,
  output dor_side_t          side_o
);

  localparam logic [35:0] Atan = {4'b0, atan_q30(5'(STAGE))};

  logic           valid_q;
  dor_vec_t [1:0] vec_d, vec_q;
  dor_side_t      side_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (!vec_i[k].y[35]) begin
        vec_d[k].x = $signed(vec_i[k].x) + ($signed(vec_i[k].y) >>> STAGE);
        vec_d[k].y = $signed(vec_i[k].y) - ($signed(vec_i[k].x) >>> STAGE);
        vec_d[k].z = vec_i[k].z + Atan;
      end else begin
        vec_d[k].x = $signed(vec_i[k].x) - ($signed(vec_i[k].y) >>> STAGE);
        vec_d[k].y = $signed(vec_i[k].y) + ($signed(vec_i[k].x) >>> STAGE);
        vec_d[k].z = vec_i[k].z - Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/dor_div_cell.sv
// One restoring division cell: produces one quotient bit of the ratio.
// Depends on dor_pkg for the sideband type, which carries the divisor.
`timescale 1ns / 1ps

module dor_div_cell import dor_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] rem_i,
  input  logic [15:0] quo_i,
  input  dor_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] rem_o,
  output logic [15:0] quo_o,
  output dor_side_t   side_o
);

  logic        valid_q;
  logic [63:0] sh, rem_d, rem_q;
  logic [15:0] quo_d, quo_q;
  dor_side_t   side_q;

  always_comb begin
    sh = rem_i << 1;
    if (sh >= {2'b0, side_i.den}) begin
      rem_d = sh - {2'b0, side_i.den};
      quo_d = {quo_i[14:0], 1'b1};
    end else begin
      rem_d = sh;
      quo_d = {quo_i[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// File: tb/sv/tb_disc_overlap_ratio_core.sv
// Testbench for disc_overlap_ratio_core: drives pairs of discs through the pipeline,
// predicts overlap ratio and touch flag in SystemVerilog, and compares in order.
// Depends on dor_pkg and the disc_overlap_ratio_core RTL.
`timescale 1ns / 1ps

module tb_disc_overlap_ratio_core;
  import dor_pkg::*;

  localparam int unsigned Stages = 16;
  localparam int unsigned Latency = 59 + Stages;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;

  // One item: two discs, each as raw Q11.4 codes.
  typedef struct packed {
    logic [15:0] x0, y0, r0, x1, y1, r1;
  } disc_pair_t;

  // One result as the block should present it.
  typedef struct packed {
    logic [16:0] ratio;
    logic        touch;
  } overlap_t;

  logic        clk, rst_n, start, busy, done, touch_out;
  logic [15:0] x0, y0, r0, x1, y1, r1;
  logic [16:0] ratio_out;

  disc_pair_t pending_pairs[$];
  overlap_t   expected_overlaps[$];
  int         error_count = 0;
  bit         stimulus_done = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         sent = 0;
  bit         drained_once = 0;

  disc_overlap_ratio_core #(.CORDIC_STAGES(Stages)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .first_center_x_i(x0), .first_center_y_i(y0), .first_radius_i(r0),
    .second_center_x_i(x1), .second_center_y_i(y1), .second_radius_i(r1),
    .done_o(done), .overlap_ratio_o(ratio_out), .discs_touch_o(touch_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Floor square root by digit recurrence.
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned rem, root, bit_w;
    rem = v;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Angle of the vector (p, s) in Q30 radians via vectoring CORDIC.
  // Arithmetic right shift on signed longint floors, as the block needs.
  function automatic longint vector_angle(input longint p, input longint s);
    longint x, y, z, t;
    if (p < 0) begin
      x = s; y = -p; z = HalfPiQ30;
    end else begin
      x = p; y = s; z = 0;
    end
    while ((x > y ? x : y) < (64'sd1 << 30)) begin
      x = x <<< 1; y = y <<< 1;
    end
    while ((x > y ? x : y) >= (64'sd1 << 31)) begin
      x = x >>> 1; y = y >>> 1;
    end
    for (int i = 0; i < Stages && i < AtanEntries; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + longint'(atan_q30(5'(i)));
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - longint'(atan_q30(5'(i)));
      end
    end
    return z;
  endfunction

  // Expected ratio and touch flag for one pair of discs.
  function automatic overlap_t predict_overlap(input disc_pair_t pr);
    longint dx, dy, ra, rb, rmin, q0, q1, p0, p1, area, den, rem;
    longint unsigned d2, sum2, diff2, s;
    overlap_t res;
    dx = longint'($signed(pr.x1)) - longint'($signed(pr.x0));
    dy = longint'($signed(pr.y1)) - longint'($signed(pr.y0));
    ra = longint'($signed(pr.r0));
    rb = longint'($signed(pr.r1));
    if (ra < 0) ra = -ra;
    if (rb < 0) rb = -rb;
    rmin = (ra < rb) ? ra : rb;
    d2 = dx * dx + dy * dy;
    sum2 = (ra + rb) * (ra + rb);
    diff2 = (ra - rb) * (ra - rb);
    res.touch = (d2 <= sum2);
    res.ratio = '0;
    if (rmin != 0 && res.touch) begin
      if (d2 <= diff2) begin
        res.ratio = RATIO_ONE;
      end else if (d2 < sum2) begin
        s = isqrt((sum2 - d2) * (d2 - diff2));
        q0 = ra * ra;
        q1 = rb * rb;
        p0 = q0 + longint'(d2) - q1;
        p1 = q1 + longint'(d2) - q0;
        area = q0 * vector_angle(p0, longint'(s)) + q1 * vector_angle(p1, longint'(s))
             - longint'(s << 29);
        if (area < 0) area = 0;
        den = longint'(PiQ30) * rmin * rmin;
        rem = area;
        if (rem >= den) begin
          res.ratio = RATIO_ONE;
        end else begin
          for (int k = 0; k < DivSteps; k++) begin
            rem = rem <<< 1;
            res.ratio = res.ratio << 1;
            if (rem >= den) begin
              rem = rem - den;
              res.ratio[0] = 1'b1;
            end
          end
        end
      end
    end
    return res;
  endfunction

  function automatic disc_pair_t make_pair(input int ax, input int ay, input int ar,
                                           input int bx, input int by, input int br);
    disc_pair_t pr;
    pr.x0 = 16'(ax); pr.y0 = 16'(ay); pr.r0 = 16'(ar);
    pr.x1 = 16'(bx); pr.y1 = 16'(by); pr.r1 = 16'(br);
    return pr;
  endfunction

  // A random signed code, uniform between -span and span.
  function automatic int rand_code(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Fill the queue: directed corners first, then random pairs. Most random pairs
  // are placed near each other so partial overlaps dominate; the rest are raw noise.
  initial begin
    disc_pair_t pr;
    int ra, rb, d;
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));           // both radii zero
    pending_pairs.push_back(make_pair(0, 0, 0, 10, 0, 100));        // smaller radius zero
    pending_pairs.push_back(make_pair(0, 0, 100, 500, 0, 100));     // disjoint
    pending_pairs.push_back(make_pair(0, 0, 100, 200, 0, 100));     // external tangency
    pending_pairs.push_back(make_pair(0, 0, 300, 100, 0, 100));     // strictly nested
    pending_pairs.push_back(make_pair(5, 5, 300, 5, 5, -100));      // equal centers
    pending_pairs.push_back(make_pair(0, 0, 200, 50, 0, 100));      // strictly nested
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 0, 100));     // partial overlap
    pending_pairs.push_back(make_pair(0, 0, -100, 150, 40, -80));   // negative radii
    pending_pairs.push_back(make_pair(0, 0, 100, 199, 0, 100));     // sliver overlap
    pending_pairs.push_back(make_pair(0, 0, 100, 1, 0, 100));       // near coincident
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, -32768, -32768, 32767));
    pending_pairs.push_back(make_pair(-32768, 0, -32768, 0, 0, -32768));
    pending_pairs.push_back(make_pair(0, -32768, 32767, 0, 32767, 32767));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 32767, 40000, 0, 32767));
    for (int n = 0; n < 1250; n++) begin
      if ($urandom_range(9) < 8) begin
        ra = ($urandom_range(3) == 0) ? int'($urandom_range(32768))
                                      : int'($urandom_range(2000));
        rb = ($urandom_range(3) == 0) ? int'($urandom_range(32768))
                                      : int'($urandom_range(2000));
        d = int'($urandom_range(ra + rb + 10));
        pr.x0 = 16'(rand_code(16000));
        pr.y0 = 16'(rand_code(16000));
        pr.x1 = 16'(int'($signed(pr.x0))
                    + int'($urandom_range(d)) * ($urandom_range(1) ? 1 : -1));
        pr.y1 = 16'(int'($signed(pr.y0))
                    + int'($urandom_range(d / 2)) * ($urandom_range(1) ? 1 : -1));
        pr.r0 = $urandom_range(1) ? 16'(ra) : 16'(-ra);
        pr.r1 = $urandom_range(1) ? 16'(rb) : 16'(-rb);
      end else begin
        pr = disc_pair_t'({$urandom, $urandom, $urandom});
      end
      pending_pairs.push_back(pr);
    end
  end

  // Driver: feeds pairs in bursts with random gaps. Once, midway, it waits
  // for the pipeline to drain completely before going on.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      {x0, y0, r0, x1, y1, r1} <= '0;
    end else if (!drained_once && sent == 600) begin
      start <= 1'b0;
      if (expected_overlaps.size() == 0) drained_once <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_pairs.size() == 0) begin
      start <= 1'b0;
      stimulus_done <= 1'b1;
    end else begin
      {x0, y0, r0, x1, y1, r1} <= pending_pairs.pop_front();
      start <= 1'b1;
      sent <= sent + 1;
      if (burst_left == 0) begin
        burst_left <= ($urandom_range(3) == 0) ? 200 : int'($urandom_range(1, 20));
        gap_left <= ($urandom_range(4) == 0) ? int'($urandom_range(1, 80))
                                             : int'($urandom_range(0, 3));
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Accepted items are recorded at the same edge the block takes them.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_overlaps.push_back(predict_overlap({x0, y0, r0, x1, y1, r1}));
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    overlap_t exp_res;
    if (rst_n && done) begin
      if (expected_overlaps.size() == 0) begin
        $error("result with no item outstanding: ratio %0d touch %0b", ratio_out, touch_out);
        error_count++;
      end else begin
        exp_res = expected_overlaps.pop_front();
        if (ratio_out !== exp_res.ratio) begin
          $error("overlap_ratio: expected %0d, got %0d", exp_res.ratio, ratio_out);
          error_count++;
        end
        if (touch_out !== exp_res.touch) begin
          $error("discs_touch: expected %0b, got %0b", exp_res.touch, touch_out);
          error_count++;
        end
      end
    end
  end

  // End of run: drain, then allow a quiet period for stray results.
  initial begin
    wait (stimulus_done);
    while (expected_overlaps.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (error_count == 0 && expected_overlaps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/dor_pkg.sv
rtl/core/dor_sqrt_cell.sv
rtl/core/dor_cordic_cell.sv
rtl/core/dor_div_cell.sv
rtl/core/disc_overlap_ratio_core.sv
tb/sv/tb_disc_overlap_ratio_core.sv
